// ----- rtl/vgu_pkg.sv -----
// Shared constants and types for the 3-vector geometry unit.
// No dependencies; imported by every module of the block.
package vgu_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int SQRT_STAGES   = 32;

  typedef logic [2:0]         op_t;
  typedef logic signed [31:0] word_t;

  localparam op_t OP_LEN   = 3'd0;
  localparam op_t OP_NORM  = 3'd1;
  localparam op_t OP_DOT   = 3'd2;
  localparam op_t OP_CROSS = 3'd3;
  localparam op_t OP_COS   = 3'd4;

  localparam word_t WORD_MAX = 32'sh7fffffff;
  localparam word_t WORD_MIN = 32'sh80000000;

endpackage

// ----- rtl/vgu_prod_lane.sv -----
// One component lane: two registered 32x32 signed products, operands picked by op.
// Depends on vgu_pkg.
module vgu_prod_lane import vgu_pkg::*; #(
  parameter int LANE = 0
) (
  input  logic                clk,
  input  logic                en,
  input  op_t                 op,
  input  word_t [2:0]         u,
  input  word_t [2:0]         v,
  output logic signed [63:0]  pa_r,
  output logic signed [63:0]  pb_r
);

  localparam int IA = (LANE + 1) % 3;
  localparam int IB = (LANE + 2) % 3;

  logic signed [31:0] a1, b1, a2, b2;

  always_comb begin
    case (op)
      OP_CROSS: begin
        a1 = $signed(u[IA]); b1 = $signed(v[IB]);
        a2 = $signed(u[IB]); b2 = $signed(v[IA]);
      end
      OP_DOT: begin
        a1 = $signed(u[LANE]); b1 = $signed(v[LANE]);
        a2 = $signed(v[LANE]); b2 = $signed(v[LANE]);
      end
      default: begin
        a1 = $signed(u[LANE]); b1 = $signed(u[LANE]);
        a2 = $signed(v[LANE]); b2 = $signed(v[LANE]);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r <= a1 * b1;
      pb_r <= a2 * b2;
    end
  end

endmodule

// ----- rtl/vgu_sqrt_pipe.sv -----
// Pipelined 64-bit integer square root, one result bit per stage.
// Depends on vgu_pkg.
module vgu_sqrt_pipe import vgu_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad,
  output logic [31:0] root
);

  logic [63:0] rem_r [SQRT_STAGES];
  logic [63:0] res_r [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] rin, qin, trial;
    if (k == 0) begin : g_first
      assign rin = rad;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_r[k-1];
      assign qin = res_r[k-1];
    end
    assign trial = qin + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rin >= trial) begin
          rem_r[k] <= rin - trial;
          res_r[k] <= (qin >> 1) + BIT;
        end else begin
          rem_r[k] <= rin;
          res_r[k] <= qin >> 1;
        end
      end
    end
  end

  assign root = res_r[SQRT_STAGES-1][31:0];

endmodule

// ----- rtl/vgu_div_pipe.sv -----
// Pipelined restoring divider: (num << FRAC_BITS) / den, quotient of FRAC_BITS+1 bits.
// Depends on vgu_pkg.
module vgu_div_pipe import vgu_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [31:0]          num,
  input  logic [31:0]          den,
  output logic [FRAC_BITS:0]   quo
);

  localparam int DW = 33 + FRAC_BITS;
  localparam int QW = FRAC_BITS + 1;

  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [31:0]   den_r [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int J = FRAC_BITS - s;
    logic [DW-1:0] rin, dsh;
    logic [QW-1:0] qin;
    logic [31:0]   din;
    if (s == 0) begin : g_first
      assign rin = DW'({num, {FRAC_BITS{1'b0}}});
      assign qin = '0;
      assign din = den;
    end else begin : g_next
      assign rin = rem_r[s-1];
      assign qin = quo_r[s-1];
      assign din = den_r[s-1];
    end
    assign dsh = DW'(din) << J;
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[s] <= din;
        if (rin >= dsh) begin
          rem_r[s] <= rin - dsh;
          quo_r[s] <= qin | (QW'(1) << J);
        end else begin
          rem_r[s] <= rin;
          quo_r[s] <= qin;
        end
      end
    end
  end

  assign quo = quo_r[QW-1];

endmodule

// ----- rtl/vgu_delay.sv -----
// Enabled shift line that carries side data alongside the arithmetic pipes.
// Depends on vgu_pkg.
module vgu_delay import vgu_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = SQRT_STAGES
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [DEPTH-1:0][W-1:0] pipe_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r[0] <= d;
      for (int k = 1; k < DEPTH; k++) begin
        pipe_r[k] <= pipe_r[k-1];
      end
    end
  end

  assign q = pipe_r[DEPTH-1];

endmodule

// ----- rtl/vector3_geometry_unit.sv -----
// 3-vector geometry unit: length, normalize, dot, cross, cosine on Q16.16 vectors.
// Depends on vgu_pkg, vgu_prod_lane, vgu_sqrt_pipe, vgu_div_pipe, vgu_delay.
//
// Usage:
//   Input channel (in_valid/in_stall) carries in_op and vectors u, v. Result
//   channel (out_valid/out_stall) carries one result transaction per input.
//   Every operation runs through the same pipeline, so results leave in order.
//   Pipeline, from accept to out_valid: input register, three lanes of products,
//   merge, a 32-stage square root, a FRAC_BITS+1 stage divider per component,
//   cosine products, output register.
//   Throughput: one transaction per cycle while the pipeline is not stalled.
//   Stall: when the output register holds an untaken result and the last
//   pipeline stage is occupied, the whole pipeline holds and in_stall rises;
//   otherwise the pipeline keeps moving and keeps accepting.
//   Reset (rst_n low, synchronous) empties the pipeline and the output register.
//   Unused op codes return all-zero results.
module vector3_geometry_unit import vgu_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  op_t   in_op,
  input  word_t in_u_x,
  input  word_t in_u_y,
  input  word_t in_u_z,
  input  word_t in_v_x,
  input  word_t in_v_y,
  input  word_t in_v_z,
  output logic  out_valid,
  input  logic  out_stall,
  output word_t out_res_x,
  output word_t out_res_y,
  output word_t out_res_z,
  output word_t out_scalar_out,
  output logic  out_zero_length,
  output logic  out_saturated
);

  localparam int DIV_STAGES = FRAC_BITS + 1;
  localparam int VLD_LEN    = SQRT_STAGES + DIV_STAGES + 4;
  localparam int QW         = FRAC_BITS + 1;
  localparam int NW         = FRAC_BITS + 2;
  localparam int PW         = 2 * NW;
  localparam int CW         = PW + 2;
  localparam int P1W        = 3 + 3 + 3 + 96 + 96 + 96 + 32 + 1;
  localparam int P2W        = 3 + 3 + 3 + 32 + 1 + 1 + 96 + 32 + 1;

  localparam logic signed [65:0] DOT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] DOT_MIN = -66'sd2147483648;
  localparam logic signed [64:0] CRS_MAX = 65'sd2147483647;
  localparam logic signed [64:0] CRS_MIN = -65'sd2147483648;
  localparam logic signed [CW-1:0] ONE   = CW'(1) << FRAC_BITS;

  logic               adv;
  logic [VLD_LEN-1:0] vld_r;

  // stage 0: input register
  op_t         op0_r;
  word_t [2:0] u0_r, v0_r;

  // stage 1: lane products
  op_t                op1_r;
  word_t [2:0]        u1_r;
  logic signed [63:0] pa [3];
  logic signed [63:0] pb [3];

  // stage 2: merge
  op_t                op2_r;
  logic [63:0]        squ2_r, sqv2_r;
  logic signed [65:0] dot2_r;
  logic signed [64:0] crs2_r [3];
  logic [2:0][31:0]   magu2_r, magv2_r;
  logic [2:0]         negu2_r, negv2_r;
  word_t [2:0]        v1_r;

  logic signed [65:0] dot_sh;
  logic signed [64:0] crs_sh [3];
  logic [2:0][31:0]   res_dc;
  logic [31:0]        scal_dc;
  logic               sat_dc;

  // after square root
  logic [P1W-1:0]   p1_in, p1_out;
  op_t              op34;
  logic [2:0]       negu34, negv34;
  logic [2:0][31:0] magu34, magv34, res34;
  logic [31:0]      scal34;
  logic             sat34;
  logic [31:0]      lenu, lenv;
  logic             zu, zv;

  // after divide
  logic [P2W-1:0]   p2_in, p2_out;
  op_t              opg;
  logic [2:0]       negug, negvg;
  logic [31:0]      lenug;
  logic             zug, zvg;
  logic [2:0][31:0] resg;
  logic [31:0]      scalg;
  logic             satg;
  logic [QW-1:0]    qu [3];
  logic [QW-1:0]    qv [3];
  logic signed [NW-1:0] nu [3];
  logic signed [NW-1:0] nv [3];

  // stage H: cosine products
  op_t                  oph_r;
  logic [31:0]          lenh_r;
  logic                 zuh_r, zvh_r;
  logic [2:0][31:0]     resh_r;
  logic [31:0]          scalh_r;
  logic                 sath_r;
  logic signed [NW-1:0] nuh_r [3];
  logic signed [PW-1:0] pch_r [3];

  logic signed [CW-1:0] cs, csh, csc;
  logic [31:0]          cos32;

  logic  out_valid_r;
  word_t res_x_r, res_y_r, res_z_r, scal_r;
  logic  zl_r, sat_r;
  word_t res_x_nxt, res_y_nxt, res_z_nxt, scal_nxt;
  logic  zl_nxt, sat_nxt;

  assign adv      = !vld_r[VLD_LEN-1] || !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[VLD_LEN-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op0_r <= in_op;
      u0_r  <= {in_u_z, in_u_y, in_u_x};
      v0_r  <= {in_v_z, in_v_y, in_v_x};
      op1_r <= op0_r;
      u1_r  <= u0_r;
      v1_r  <= v0_r;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    vgu_prod_lane #(.LANE(i)) u_lane (
      .clk  (clk),
      .en   (adv),
      .op   (op0_r),
      .u    (u0_r),
      .v    (v0_r),
      .pa_r (pa[i]),
      .pb_r (pb[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op2_r  <= op1_r;
      squ2_r <= 64'(pa[0]) + 64'(pa[1]) + 64'(pa[2]);
      sqv2_r <= 64'(pb[0]) + 64'(pb[1]) + 64'(pb[2]);
      dot2_r <= 66'(pa[0]) + 66'(pa[1]) + 66'(pa[2]);
      for (int i = 0; i < 3; i++) begin
        crs2_r[i]  <= 65'(pa[i]) - 65'(pb[i]);
        negu2_r[i] <= u1_r[i][31];
        negv2_r[i] <= v1_r[i][31];
        magu2_r[i] <= u1_r[i][31] ? (~u1_r[i] + 32'd1) : u1_r[i];
        magv2_r[i] <= v1_r[i][31] ? (~v1_r[i] + 32'd1) : v1_r[i];
      end
    end
  end

  always_comb begin
    dot_sh  = dot2_r >>> FRAC_BITS;
    sat_dc  = 1'b0;
    scal_dc = '0;
    res_dc  = '0;
    for (int i = 0; i < 3; i++) begin
      crs_sh[i] = crs2_r[i] >>> FRAC_BITS;
    end
    if (op2_r == OP_DOT) begin
      if (dot_sh > DOT_MAX) begin
        scal_dc = WORD_MAX; sat_dc = 1'b1;
      end else if (dot_sh < DOT_MIN) begin
        scal_dc = WORD_MIN; sat_dc = 1'b1;
      end else begin
        scal_dc = dot_sh[31:0];
      end
    end
    if (op2_r == OP_CROSS) begin
      for (int i = 0; i < 3; i++) begin
        if (crs_sh[i] > CRS_MAX) begin
          res_dc[i] = WORD_MAX; sat_dc = 1'b1;
        end else if (crs_sh[i] < CRS_MIN) begin
          res_dc[i] = WORD_MIN; sat_dc = 1'b1;
        end else begin
          res_dc[i] = crs_sh[i][31:0];
        end
      end
    end
  end

  vgu_sqrt_pipe u_sqrt_u (.clk(clk), .en(adv), .rad(squ2_r), .root(lenu));
  vgu_sqrt_pipe u_sqrt_v (.clk(clk), .en(adv), .rad(sqv2_r), .root(lenv));

  assign p1_in = {op2_r, negu2_r, negv2_r, magu2_r, magv2_r, res_dc, scal_dc, sat_dc};

  vgu_delay #(.W(P1W), .DEPTH(SQRT_STAGES)) u_dly_sqrt (
    .clk (clk),
    .en  (adv),
    .d   (p1_in),
    .q   (p1_out)
  );

  assign {op34, negu34, negv34, magu34, magv34, res34, scal34, sat34} = p1_out;
  assign zu = (lenu == 32'd0);
  assign zv = (lenv == 32'd0);

  for (genvar i = 0; i < 3; i++) begin : g_div
    vgu_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div_u (
      .clk (clk), .en(adv), .num(magu34[i]), .den(lenu), .quo(qu[i])
    );
    vgu_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div_v (
      .clk (clk), .en(adv), .num(magv34[i]), .den(lenv), .quo(qv[i])
    );
    assign nu[i] = negug[i] ? -$signed({1'b0, qu[i]}) : $signed({1'b0, qu[i]});
    assign nv[i] = negvg[i] ? -$signed({1'b0, qv[i]}) : $signed({1'b0, qv[i]});
  end

  assign p2_in = {op34, negu34, negv34, lenu, zu, zv, res34, scal34, sat34};

  vgu_delay #(.W(P2W), .DEPTH(DIV_STAGES)) u_dly_div (
    .clk (clk),
    .en  (adv),
    .d   (p2_in),
    .q   (p2_out)
  );

  assign {opg, negug, negvg, lenug, zug, zvg, resg, scalg, satg} = p2_out;

  always_ff @(posedge clk) begin
    if (adv) begin
      oph_r   <= opg;
      lenh_r  <= lenug;
      zuh_r   <= zug;
      zvh_r   <= zvg;
      resh_r  <= resg;
      scalh_r <= scalg;
      sath_r  <= satg;
      for (int i = 0; i < 3; i++) begin
        nuh_r[i] <= nu[i];
        pch_r[i] <= nu[i] * nv[i];
      end
    end
  end

  always_comb begin
    cs  = CW'(pch_r[0]) + CW'(pch_r[1]) + CW'(pch_r[2]);
    csh = cs >>> FRAC_BITS;
    if (csh > ONE) begin
      csc = ONE;
    end else if (csh < -ONE) begin
      csc = -ONE;
    end else begin
      csc = csh;
    end
    cos32 = 32'($signed(csc[NW-1:0]));
  end

  always_comb begin
    res_x_nxt = '0;
    res_y_nxt = '0;
    res_z_nxt = '0;
    scal_nxt  = '0;
    zl_nxt    = 1'b0;
    sat_nxt   = 1'b0;
    case (oph_r)
      OP_LEN: begin
        scal_nxt = lenh_r[31] ? WORD_MAX : lenh_r;
        sat_nxt  = lenh_r[31];
      end
      OP_NORM: begin
        zl_nxt = zuh_r;
        if (!zuh_r) begin
          res_x_nxt = 32'(nuh_r[0]);
          res_y_nxt = 32'(nuh_r[1]);
          res_z_nxt = 32'(nuh_r[2]);
        end
      end
      OP_DOT: begin
        scal_nxt = scalh_r;
        sat_nxt  = sath_r;
      end
      OP_CROSS: begin
        res_x_nxt = resh_r[0];
        res_y_nxt = resh_r[1];
        res_z_nxt = resh_r[2];
        sat_nxt   = sath_r;
      end
      OP_COS: begin
        zl_nxt = zuh_r || zvh_r;
        if (!(zuh_r || zvh_r)) begin
          scal_nxt = cos32;
        end
      end
      default: begin
        scal_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && vld_r[VLD_LEN-1]) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld_r[VLD_LEN-1]) begin
      res_x_r <= res_x_nxt;
      res_y_r <= res_y_nxt;
      res_z_r <= res_z_nxt;
      scal_r  <= scal_nxt;
      zl_r    <= zl_nxt;
      sat_r   <= sat_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_res_x       = res_x_r;
  assign out_res_y       = res_y_r;
  assign out_res_z       = res_z_r;
  assign out_scalar_out  = scal_r;
  assign out_zero_length = zl_r;
  assign out_saturated   = sat_r;

endmodule
